// ===== rtl/core/cdq_pkg.sv =====
// Shared types, operation codes and constants for the circular double-ended queue.
`default_nettype none
package cdq_pkg;

	localparam int DATA_W            = 32;
	localparam int OP_W              = 3;
	localparam int CAP_W             = 11;
	localparam int CAP_RESET         = 1024;
	localparam int MAX_DEPTH_DEFAULT = 1024;
	localparam int TUSER_OUT_W       = 3;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic latch;  // capture the accepted operation
		logic exec;   // update pointers, access the store
		logic load;   // fill the result register
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/circular_double_ended_queue.sv =====
// Top level of the circular double-ended queue: controller, datapath and checks.
//
//   channel   direction  handshake                       payload
//   s_axis    in         s_axis_tvalid / s_axis_tready   tdata push_value, tuser operation
//   m_axis    out        m_axis_tvalid / m_axis_tready   tdata read_value, tuser flags
//   cfg       in         cfg_valid / cfg_ready           cfg_data capacity
//
// Each operation runs these steps from accept to result: accept, one store
// access with pointer update, then the registered read data fills the result
// register; the single-port entry store and the sequencer set this sequence.
// A new operation is taken only while the sequencer is idle and the result
// register is empty or draining. Reset empties the queue and sets capacity to
// 1024 (clamped to MAX_DEPTH); stored words are not cleared. cfg_ready is always high.
`default_nettype none
module circular_double_ended_queue #(
	parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire  [cdq_pkg::DATA_W-1:0]           s_axis_tdata,  // [31:0] push_value
	input  wire  [cdq_pkg::OP_W-1:0]             s_axis_tuser,  // [2:0] operation
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [cdq_pkg::DATA_W-1:0]           m_axis_tdata,  // [31:0] read_value
	output logic [cdq_pkg::TUSER_OUT_W-1:0]      m_axis_tuser,  // [0] success, [1] is_empty,
	                                                            // [2] is_full
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [cdq_pkg::CAP_W-1:0]            cfg_data       // [10:0] capacity
);

	cdq_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	cdq_dpath #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (s_axis_tuser),
		.push_value (s_axis_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_cap    (cfg_data),
		.read_value (m_axis_tdata),
		.flags      (m_axis_tuser)
	);

	// every accepted transaction yields its result after the execute and result-load states
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> ##3 m_axis_tvalid)
		else $error("result did not appear three cycles after accept");

	// no accept while a result is stalled
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("input accepted while result register was blocked");

	// capacity is at least one, so empty and full never coincide
	a_empty_full_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2]))
		else $error("result flags report empty and full together");

endmodule
`default_nettype wire

// ===== rtl/core/cdq_ctrl.sv =====
// Controller state machine: sequences accept, execute and result load.
`default_nettype none
module cdq_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	output cdq_pkg::cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	// accept only when the result register is free or drains this cycle
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign cmd.latch = in_valid && in_ready;
	assign cmd.exec  = (state_q == ST_EXEC);
	assign cmd.load  = (state_q == ST_DONE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.latch) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/cdq_dpath.sv =====
// Datapath: entry store, ring pointers, entry count, capacity and result register.
`default_nettype none
module cdq_dpath #(
	parameter int MAX_DEPTH = cdq_pkg::MAX_DEPTH_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  cdq_pkg::cmd_t                        cmd,
	input  wire  [cdq_pkg::OP_W-1:0]             op,
	input  wire  [cdq_pkg::DATA_W-1:0]           push_value,
	input  wire                                  cfg_we,
	input  wire  [cdq_pkg::CAP_W-1:0]            cfg_cap,
	output logic [cdq_pkg::DATA_W-1:0]           read_value,
	output logic [cdq_pkg::TUSER_OUT_W-1:0]      flags
);

	localparam int AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CNTW    = $clog2(MAX_DEPTH + 1);
	localparam int CAP_RST = (cdq_pkg::CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : cdq_pkg::CAP_RESET;

	logic [cdq_pkg::DATA_W-1:0] mem_q [MAX_DEPTH];
	logic [cdq_pkg::DATA_W-1:0] rdata_q;

	logic [cdq_pkg::OP_W-1:0]   op_q;
	logic [cdq_pkg::DATA_W-1:0] value_q;
	logic [AW-1:0]              front_q;
	logic [AW-1:0]              back_q;
	logic [CNTW-1:0]            count_q;
	logic [CNTW-1:0]            cap_q;

	logic                       ok_q;
	logic                       peek_q;
	logic                       empty_q;
	logic                       full_q;
	logic [cdq_pkg::DATA_W-1:0] rv_q;
	logic [cdq_pkg::TUSER_OUT_W-1:0] flags_q;

	logic [31:0]     cap_raw;
	logic [CNTW-1:0] cap_eff;
	logic [CNTW-1:0] cap_m1;
	logic [CNTW-1:0] front_inc;
	logic [CNTW-1:0] back_inc;
	logic [AW-1:0]   front_up;
	logic [AW-1:0]   front_dn;
	logic [AW-1:0]   back_up;
	logic [AW-1:0]   back_dn;
	logic            not_full;
	logic            not_empty;

	logic [AW-1:0]   front_d;
	logic [AW-1:0]   back_d;
	logic [CNTW-1:0] count_d;
	logic            ok_d;
	logic            peek_d;
	logic            wr_en;
	logic            rd_en;
	logic [AW-1:0]   addr;

	// clamp the written capacity to 1..MAX_DEPTH
	always_comb begin
		cap_raw = 32'(cfg_cap);
		if (cap_raw == 32'd0) begin
			cap_eff = CNTW'(1);
		end else if (cap_raw > 32'(MAX_DEPTH)) begin
			cap_eff = CNTW'(MAX_DEPTH);
		end else begin
			cap_eff = CNTW'(cap_raw);
		end
	end

	assign cap_m1    = cap_q - CNTW'(1);
	assign front_inc = CNTW'(front_q) + CNTW'(1);
	assign back_inc  = CNTW'(back_q) + CNTW'(1);
	assign front_up  = (front_inc >= cap_q) ? '0 : front_inc[AW-1:0];
	assign back_up   = (back_inc >= cap_q) ? '0 : back_inc[AW-1:0];
	assign front_dn  = (front_q == '0) ? cap_m1[AW-1:0] : front_q - AW'(1);
	assign back_dn   = (back_q == '0) ? cap_m1[AW-1:0] : back_q - AW'(1);
	assign not_full  = (count_q < cap_q);
	assign not_empty = (count_q != '0);

	always_comb begin
		front_d = front_q;
		back_d  = back_q;
		count_d = count_q;
		ok_d    = 1'b0;
		peek_d  = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		addr    = front_q;
		case (op_q)
			cdq_pkg::OP_PUSH_FRONT: begin
				if (not_full) begin
					front_d = front_dn;
					addr    = front_dn;
					wr_en   = 1'b1;
					count_d = count_q + CNTW'(1);
					ok_d    = 1'b1;
				end
			end
			cdq_pkg::OP_PUSH_BACK: begin
				if (not_full) begin
					back_d  = back_up;
					addr    = back_q;
					wr_en   = 1'b1;
					count_d = count_q + CNTW'(1);
					ok_d    = 1'b1;
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (not_empty) begin
					front_d = front_up;
					count_d = count_q - CNTW'(1);
					ok_d    = 1'b1;
				end
			end
			cdq_pkg::OP_POP_BACK: begin
				if (not_empty) begin
					back_d  = back_dn;
					count_d = count_q - CNTW'(1);
					ok_d    = 1'b1;
				end
			end
			cdq_pkg::OP_PEEK_FRONT: begin
				peek_d = 1'b1;
				addr   = front_q;
				rd_en  = not_empty;
				ok_d   = not_empty;
			end
			cdq_pkg::OP_PEEK_BACK: begin
				peek_d = 1'b1;
				addr   = back_dn;
				rd_en  = not_empty;
				ok_d   = not_empty;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) mem_q[addr] <= value_q;
		if (cmd.exec && rd_en) rdata_q <= mem_q[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op;
			value_q <= push_value;
		end
		if (cmd.exec) begin
			ok_q    <= ok_d;
			peek_q  <= peek_d;
			empty_q <= (count_d == '0);
			full_q  <= (count_d >= cap_q);
		end
		if (cmd.load) begin
			if (!peek_q) begin
				rv_q <= '0;
			end else if (ok_q) begin
				rv_q <= rdata_q;
			end else begin
				rv_q <= '1;
			end
			flags_q <= {full_q, empty_q, ok_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			cap_q   <= CNTW'(CAP_RST);
		end else if (cfg_we) begin
			// a capacity write also empties the queue
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
			cap_q   <= cap_eff;
		end else if (cmd.exec) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	assign read_value = rv_q;
	assign flags      = flags_q;

endmodule
`default_nettype wire
